FILE: rtl/acma_pkg.sv
package acma_pkg;

  localparam int OpW    = 5;
  localparam int BitW   = 3;
  localparam int ByteW  = 8;
  localparam int InW    = 16;
  localparam int OutW   = 40;

  localparam int DivDataW  = 16;
  localparam int DivRemW   = 9;
  localparam int DivBits   = 2;
  localparam int DivSteps  = DivDataW / DivBits;
  localparam int DivCntW   = $clog2(DivSteps);

  localparam int FlagN = 7;
  localparam int FlagV = 6;
  localparam int FlagP = 5;
  localparam int FlagH = 3;
  localparam int FlagI = 2;
  localparam int FlagZ = 1;
  localparam int FlagC = 0;

  typedef enum logic [OpW-1:0] {
    OP_NOP      = 5'd0,
    OP_XCN      = 5'd1,
    OP_DAA      = 5'd2,
    OP_DAS      = 5'd3,
    OP_CLRC     = 5'd4,
    OP_SETC     = 5'd5,
    OP_NOTC     = 5'd6,
    OP_CLRP     = 5'd7,
    OP_SETP     = 5'd8,
    OP_CLRV     = 5'd9,
    OP_EI       = 5'd10,
    OP_DI       = 5'd11,
    OP_MUL      = 5'd12,
    OP_DIV      = 5'd13,
    OP_SETBIT   = 5'd14,
    OP_CLRBIT   = 5'd15,
    OP_POP_A    = 5'd16,
    OP_POP_X    = 5'd17,
    OP_POP_Y    = 5'd18,
    OP_POP_PSW  = 5'd19,
    OP_PUSH_A   = 5'd20,
    OP_PUSH_X   = 5'd21,
    OP_PUSH_Y   = 5'd22,
    OP_PUSH_PSW = 5'd23
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic div_start;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic op_is_div;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/audio_cpu_misc_alu.sv
// Miscellaneous-instruction unit of an 8-bit sound CPU. It holds the A, X, Y and
// status registers and executes one instruction per input word.
// The input stream carries the operation code, a bit index and a data byte; the
// output stream carries one word per instruction with A, X, Y, the status byte
// and the byte that a bit operation or a push produces.
// An instruction accepted at one clock edge is registered and executed in the
// next cycle; its word is loaded into the output register once that is free.
// Divide runs through an iterative divider that retires two quotient bits per
// cycle and never stalls; the word is loaded when it is done and output is free.
// The input side is ready again in the cycle after the word is loaded, so the
// next instruction is taken while the previous word still waits at the output,
// but no instruction is taken while one is still executing.
// When the receiver stalls, the output word holds and the instruction being
// executed waits for the output register to free before it updates the
// registers. Reset clears A, X, Y, the status byte and the output valid.
module audio_cpu_misc_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation [4:0], bit_index [7:5], data_byte [15:8]
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // acc_out [7:0], x_out [15:8], y_out [23:16], flags_out [31:24], byte_out [39:32]
  output logic [39:0] m_tdata
);

  acma_pkg::cmd_t    cmd;
  acma_pkg::status_t sts;

  acma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  acma_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (m_tdata)
  );

endmodule

FILE: rtl/acma_ctrl.sv
module acma_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  acma_pkg::status_t  sts,
  output acma_pkg::cmd_t     cmd
);

  acma_pkg::state_t                 state, state_next;
  logic [acma_pkg::DivCntW-1:0]     step_cnt, step_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= acma_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    s_tready      = 1'b0;
    case (state)
      acma_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next   = acma_pkg::ST_EXEC;
        end
      end
      acma_pkg::ST_EXEC: begin
        if (sts.op_is_div) begin
          cmd.div_start = 1'b1;
          step_cnt_next = '0;
          state_next    = acma_pkg::ST_DIV;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = acma_pkg::ST_IDLE;
        end
      end
      acma_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_cnt == acma_pkg::DivCntW'(acma_pkg::DivSteps - 1)) begin
          state_next = acma_pkg::ST_FIN;
        end else begin
          step_cnt_next = step_cnt + acma_pkg::DivCntW'(1);
        end
      end
      acma_pkg::ST_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = acma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = acma_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/acma_dp.sv
module acma_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [acma_pkg::InW-1:0]      in_word,
  input  acma_pkg::cmd_t                cmd,
  output acma_pkg::status_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [acma_pkg::OutW-1:0]     out_word
);

  logic [7:0] acc, xr, yr, flags;
  logic [7:0] acc_next, x_next, y_next, flags_next, byte_next;

  acma_pkg::op_t                     in_op;
  logic [acma_pkg::BitW-1:0]         in_bit;
  logic [acma_pkg::ByteW-1:0]        in_data;

  logic [acma_pkg::DivDataW-1:0]     div_q, div_q_next;
  logic [acma_pkg::DivRemW-1:0]      div_rem, div_rem_next;
  logic [acma_pkg::DivRemW-1:0]      div_dvs;
  logic                              div_range;

  logic                              range_now;
  logic [16:0]                       shifted_ya;
  logic [acma_pkg::DivRemW-1:0]      dvs_now;

  logic [7:0]  daa1, daa2, das1, das2, bit_mask;
  logic [15:0] prod;
  logic [7:0]  div_acc, div_y;

  assign range_now  = {1'b0, yr} < {xr, 1'b0};
  assign shifted_ya = {1'b0, yr, acc} - {xr, 9'd0};
  assign dvs_now    = range_now ? {1'b0, xr} : (9'd256 - {1'b0, xr});

  always_comb begin
    logic [acma_pkg::DivRemW-1:0] r;
    logic [acma_pkg::DivDataW-1:0] q;
    logic [acma_pkg::DivRemW:0]    t;
    r = div_rem;
    q = div_q;
    for (int i = 0; i < acma_pkg::DivBits; i++) begin
      t = {r, q[acma_pkg::DivDataW-1]};
      q = {q[acma_pkg::DivDataW-2:0], 1'b0};
      if (t >= {1'b0, div_dvs}) begin
        t    = t - {1'b0, div_dvs};
        q[0] = 1'b1;
      end
      r = t[acma_pkg::DivRemW-1:0];
    end
    div_rem_next = r;
    div_q_next   = q;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_op   <= acma_pkg::op_t'(in_word[4:0]);
      in_bit  <= in_word[7:5];
      in_data <= in_word[15:8];
    end
    if (cmd.div_start) begin
      div_q     <= range_now ? {yr, acc} : shifted_ya[15:0];
      div_rem   <= '0;
      div_dvs   <= dvs_now;
      div_range <= range_now;
    end else if (cmd.div_step) begin
      div_q   <= div_q_next;
      div_rem <= div_rem_next;
    end
  end

  assign div_acc  = div_range ? div_q[7:0] : (8'hFF - div_q[7:0]);
  assign div_y    = div_range ? div_rem[7:0] : (xr + div_rem[7:0]);
  assign prod     = {8'd0, yr} * {8'd0, acc};
  assign bit_mask = 8'd1 << in_bit;

  assign daa1 = (flags[acma_pkg::FlagC] || acc > 8'h99) ? acc + 8'h60 : acc;
  assign daa2 = (flags[acma_pkg::FlagH] || daa1[3:0] > 4'h9) ? daa1 + 8'h06 : daa1;
  assign das1 = (!flags[acma_pkg::FlagC] || acc > 8'h99) ? acc - 8'h60 : acc;
  assign das2 = (!flags[acma_pkg::FlagH] || das1[3:0] > 4'h9) ? das1 - 8'h06 : das1;

  always_comb begin
    acc_next   = acc;
    x_next     = xr;
    y_next     = yr;
    flags_next = flags;
    byte_next  = '0;
    case (in_op)
      acma_pkg::OP_XCN: begin
        acc_next = {acc[3:0], acc[7:4]};
      end
      acma_pkg::OP_DAA: begin
        acc_next = daa2;
        if (flags[acma_pkg::FlagC] || acc > 8'h99) begin
          flags_next[acma_pkg::FlagC] = 1'b1;
        end
      end
      acma_pkg::OP_DAS: begin
        acc_next = das2;
        if (!flags[acma_pkg::FlagC] || acc > 8'h99) begin
          flags_next[acma_pkg::FlagC] = 1'b0;
        end
      end
      acma_pkg::OP_CLRC: flags_next[acma_pkg::FlagC] = 1'b0;
      acma_pkg::OP_SETC: flags_next[acma_pkg::FlagC] = 1'b1;
      acma_pkg::OP_NOTC: flags_next[acma_pkg::FlagC] = ~flags[acma_pkg::FlagC];
      acma_pkg::OP_CLRP: flags_next[acma_pkg::FlagP] = 1'b0;
      acma_pkg::OP_SETP: flags_next[acma_pkg::FlagP] = 1'b1;
      acma_pkg::OP_CLRV: begin
        flags_next[acma_pkg::FlagV] = 1'b0;
        flags_next[acma_pkg::FlagH] = 1'b0;
      end
      acma_pkg::OP_EI: flags_next[acma_pkg::FlagI] = 1'b1;
      acma_pkg::OP_DI: flags_next[acma_pkg::FlagI] = 1'b0;
      acma_pkg::OP_MUL: begin
        acc_next = prod[7:0];
        y_next   = prod[15:8];
      end
      acma_pkg::OP_DIV: begin
        acc_next = div_acc;
        y_next   = div_y;
        flags_next[acma_pkg::FlagV] = yr >= xr;
        flags_next[acma_pkg::FlagH] = yr[3:0] >= xr[3:0];
      end
      acma_pkg::OP_SETBIT:  byte_next = in_data | bit_mask;
      acma_pkg::OP_CLRBIT:  byte_next = in_data & ~bit_mask;
      acma_pkg::OP_POP_A:   acc_next = in_data;
      acma_pkg::OP_POP_X:   x_next = in_data;
      acma_pkg::OP_POP_Y:   y_next = in_data;
      acma_pkg::OP_POP_PSW: flags_next = in_data;
      acma_pkg::OP_PUSH_A:  byte_next = acc;
      acma_pkg::OP_PUSH_X:  byte_next = xr;
      acma_pkg::OP_PUSH_Y:  byte_next = yr;
      acma_pkg::OP_PUSH_PSW: byte_next = flags;
      default: begin
      end
    endcase
    if (in_op == acma_pkg::OP_XCN || in_op == acma_pkg::OP_DAA ||
        in_op == acma_pkg::OP_DAS || in_op == acma_pkg::OP_DIV) begin
      flags_next[acma_pkg::FlagN] = acc_next[7];
      flags_next[acma_pkg::FlagZ] = acc_next == 8'd0;
    end else if (in_op == acma_pkg::OP_MUL) begin
      flags_next[acma_pkg::FlagN] = y_next[7];
      flags_next[acma_pkg::FlagZ] = y_next == 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      xr        <= '0;
      yr        <= '0;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        acc       <= acc_next;
        xr        <= x_next;
        yr        <= y_next;
        flags     <= flags_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_word <= {byte_next, flags_next, y_next, x_next, acc_next};
    end
  end

  assign sts = {in_op == acma_pkg::OP_DIV, !out_valid || out_ready};

endmodule

FILE: rtl/acma_chk.sv
module acma_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output word valid after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled output word changed.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input accepted again while an instruction is executing.");

  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("Output word appeared without an instruction in flight.");

endmodule

bind audio_cpu_misc_alu acma_chk u_acma_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: verif/alu_word_checker.sv
`timescale 1ns / 100ps

module alu_word_checker
  import acma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // operation [4:0], bit_index [7:5], data_byte [15:8]
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // acc_out [7:0], x_out [15:8], y_out [23:16], flags_out [31:24], byte_out [39:32]
  input  logic [39:0] m_tdata,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [7:0] byte_out;
    logic [7:0] flags;
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] acc;
  } regs_word_t;

  logic [7:0] acc_r;
  logic [7:0] x_r;
  logic [7:0] y_r;
  logic [7:0] psw_r;
  regs_word_t alu_words[$];

  function automatic void set_nz(input logic [7:0] v);
    psw_r[FlagN] = v[7];
    psw_r[FlagZ] = (v == 8'h00);
  endfunction

  function automatic regs_word_t exec_insn(input logic [4:0] op, input logic [2:0] bi,
                                           input logic [7:0] db);
    regs_word_t       w;
    logic [7:0]       a0;
    logic [7:0]       res_byte;
    logic [15:0]      prod;
    logic [15:0]      ya;
    int unsigned      xv;
    int unsigned      yv;
    int unsigned      t;
    int unsigned      d;
    int unsigned      q;
    int unsigned      rem;
    res_byte = 8'h00;
    case (op)
      OP_XCN: begin
        acc_r = {acc_r[3:0], acc_r[7:4]};
        set_nz(acc_r);
      end
      OP_DAA: begin
        a0 = acc_r;
        if (psw_r[FlagC] || a0 > 8'h99) begin
          acc_r = acc_r + 8'h60;
          psw_r[FlagC] = 1'b1;
        end
        if (psw_r[FlagH] || acc_r[3:0] > 4'h9) acc_r = acc_r + 8'h06;
        set_nz(acc_r);
      end
      OP_DAS: begin
        a0 = acc_r;
        if (!psw_r[FlagC] || a0 > 8'h99) begin
          acc_r = acc_r - 8'h60;
          psw_r[FlagC] = 1'b0;
        end
        if (!psw_r[FlagH] || acc_r[3:0] > 4'h9) acc_r = acc_r - 8'h06;
        set_nz(acc_r);
      end
      OP_CLRC: psw_r[FlagC] = 1'b0;
      OP_SETC: psw_r[FlagC] = 1'b1;
      OP_NOTC: psw_r[FlagC] = ~psw_r[FlagC];
      OP_CLRP: psw_r[FlagP] = 1'b0;
      OP_SETP: psw_r[FlagP] = 1'b1;
      OP_CLRV: begin
        psw_r[FlagV] = 1'b0;
        psw_r[FlagH] = 1'b0;
      end
      OP_EI: psw_r[FlagI] = 1'b1;
      OP_DI: psw_r[FlagI] = 1'b0;
      OP_MUL: begin
        prod  = {8'h00, y_r} * {8'h00, acc_r};
        acc_r = prod[7:0];
        y_r   = prod[15:8];
        set_nz(y_r);
      end
      OP_DIV: begin
        ya = {y_r, acc_r};
        xv = x_r;
        yv = y_r;
        psw_r[FlagV] = (yv >= xv);
        psw_r[FlagH] = (y_r[3:0] >= x_r[3:0]);
        if (yv < (xv << 1)) begin
          q   = ya / xv;
          rem = ya % xv;
        end else begin
          // The chip's own result when Y is at least twice X, so the quotient cannot fit in nine bits.
          t   = ya - (xv << 9);
          d   = 256 - xv;
          q   = 255 - t / d;
          rem = xv + t % d;
        end
        acc_r = q[7:0];
        y_r   = rem[7:0];
        set_nz(acc_r);
      end
      OP_SETBIT: res_byte = db | (8'h01 << bi);
      OP_CLRBIT: res_byte = db & ~(8'h01 << bi);
      OP_POP_A: acc_r = db;
      OP_POP_X: x_r = db;
      OP_POP_Y: y_r = db;
      OP_POP_PSW: psw_r = db;
      OP_PUSH_A: res_byte = acc_r;
      OP_PUSH_X: res_byte = x_r;
      OP_PUSH_Y: res_byte = y_r;
      OP_PUSH_PSW: res_byte = psw_r;
      default: ;
    endcase
    w.acc      = acc_r;
    w.x        = x_r;
    w.y        = y_r;
    w.flags    = psw_r;
    w.byte_out = res_byte;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %02h, got %02h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    regs_word_t exp_w;
    regs_word_t act_w;
    if (rst) begin
      acc_r = 8'h00;
      x_r   = 8'h00;
      y_r   = 8'h00;
      psw_r = 8'h00;
      fail_count = 0;
      alu_words.delete();
      outstanding <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        act_w = m_tdata;
        if (alu_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected output word %010h", m_tdata);
        end else begin
          exp_w = alu_words.pop_front();
          check_field("acc_out", exp_w.acc, act_w.acc);
          check_field("x_out", exp_w.x, act_w.x);
          check_field("y_out", exp_w.y, act_w.y);
          check_field("flags_out", exp_w.flags, act_w.flags);
          check_field("byte_out", exp_w.byte_out, act_w.byte_out);
        end
      end
      if (s_tvalid && s_tready)
        alu_words.push_back(exec_insn(s_tdata[4:0], s_tdata[7:5], s_tdata[15:8]));
      outstanding <= alu_words.size();
    end
  end

endmodule

FILE: verif/tb_audio_cpu_misc_alu.sv
`timescale 1ns / 100ps

module tb_audio_cpu_misc_alu;
  import acma_pkg::*;

  localparam logic [4:0] OpUnusedLo = 5'd24;
  localparam logic [4:0] OpUnusedHi = 5'd31;
  localparam int         RandomItems = 1020;
  localparam int         CycleLimit  = 600000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = 16'h0000;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  int fail_count;
  int outstanding;
  int cycles     = 0;
  int stall_left = 0;
  bit no_gaps    = 1'b0;

  always #4 clk = ~clk;

  audio_cpu_misc_alu i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  alu_word_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls at random, except in every fourth stretch of the run, where only a stall already begun runs on.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (((cycles / 2000) % 4 == 3) || r >= 30) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= 1'b0;
      stall_left <= (r < 3) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [4:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 5'($urandom_range(OP_POP_A, OP_POP_PSW));
    if (r < 42) return OP_DIV;
    if (r < 50) return OP_MUL;
    if (r < 55) return OP_DAA;
    if (r < 60) return OP_DAS;
    if (r < 65) return 5'($urandom_range(OpUnusedLo, OpUnusedHi));
    return 5'($urandom_range(OP_NOP, OP_PUSH_PSW));
  endfunction

  task automatic send_insn(input logic [4:0] op, input logic [2:0] bi, input logic [7:0] db);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {db, bi, op};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Divide by zero X, out of range, then the flag operations.
    send_insn(OP_POP_A, 3'd0, 8'hff);
    send_insn(OP_POP_X, 3'd0, 8'h00);
    send_insn(OP_POP_Y, 3'd0, 8'hff);
    send_insn(OP_DIV, 3'd0, 8'h00);
    send_insn(OP_PUSH_A, 3'd0, 8'h00);
    send_insn(OP_POP_PSW, 3'd0, 8'hff);
    send_insn(OP_DAA, 3'd0, 8'h00);
    send_insn(OP_DAS, 3'd0, 8'h00);
    send_insn(OP_CLRV, 3'd0, 8'h00);
    send_insn(OP_CLRC, 3'd0, 8'h00);
    send_insn(OP_NOTC, 3'd0, 8'h00);
    send_insn(OP_SETC, 3'd0, 8'h00);
    send_insn(OP_CLRP, 3'd0, 8'h00);
    send_insn(OP_SETP, 3'd0, 8'h00);
    send_insn(OP_EI, 3'd0, 8'h00);
    send_insn(OP_DI, 3'd0, 8'h00);
    // Decimal adjust with the accumulator above 0x99 and the flags clear.
    send_insn(OP_POP_PSW, 3'd0, 8'h00);
    send_insn(OP_POP_A, 3'd0, 8'h9a);
    send_insn(OP_XCN, 3'd0, 8'h00);
    send_insn(OP_DAA, 3'd0, 8'h00);
    send_insn(OP_POP_Y, 3'd0, 8'hff);
    send_insn(OP_POP_A, 3'd0, 8'hff);
    send_insn(OP_MUL, 3'd0, 8'h00);
    send_insn(OP_POP_Y, 3'd0, 8'h01);
    send_insn(OP_POP_X, 3'd0, 8'h80);
    send_insn(OP_DIV, 3'd0, 8'h00);
    send_insn(OP_SETBIT, 3'd7, 8'h00);
    send_insn(OP_CLRBIT, 3'd0, 8'hff);
    send_insn(OpUnusedHi, 3'd7, 8'hff);
    send_insn(OP_PUSH_PSW, 3'd0, 8'h00);
    send_insn(OP_PUSH_X, 3'd0, 8'h00);
    send_insn(OP_PUSH_Y, 3'd0, 8'h00);
    send_insn(OP_NOP, 3'd0, 8'h00);

    for (int i = 0; i < RandomItems; i++) begin
      no_gaps = ((i / 100) % 4 == 2);
      if (i == RandomItems / 2) wait_drained();
      send_insn(pick_op(), 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/acma_pkg.sv
rtl/acma_ctrl.sv
rtl/acma_dp.sv
rtl/audio_cpu_misc_alu.sv
rtl/acma_chk.sv
verif/alu_word_checker.sv
verif/tb_audio_cpu_misc_alu.sv
